/* sv/apst_pkg.sv */
// ----------------------------------------------------------------------------
// apst_pkg
// Shared types and constants of the aging position slot table.
// ----------------------------------------------------------------------------
package apst_pkg;

  localparam int NUM_SLOTS   = 12;
  localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [3:0]         slot;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [31:0]        now_ms;
  } apst_in_t;

  typedef struct packed {
    logic               found;
    logic [3:0]         slot_index;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic               last;
  } apst_out_t;

  // classified command between front and back
  typedef struct packed {
    logic               is_query;
    logic [SLOT_W-1:0]  slot;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [31:0]        now_ms;
  } apst_cmd_t;

endpackage

/* sv/apst_front.sv */
// ----------------------------------------------------------------------------
// apst_front
// Accepts request transactions, drops out-of-range updates and hands
// classified commands to the command queue.
// ----------------------------------------------------------------------------
module apst_front (
  input  logic               req_valid,
  output logic               req_ready,
  input  apst_pkg::apst_in_t req,
  input  logic               full,
  output logic               push,
  output apst_pkg::apst_cmd_t push_cmd
);
  import apst_pkg::*;

  logic is_query;
  logic in_range;

  assign is_query  = (req.opcode == OP_QUERY);
  assign in_range  = ({1'b0, req.slot} < 5'(NUM_SLOTS));
  assign req_ready = !full;
  assign push      = req_valid && !full && (is_query || in_range);

  always_comb begin
    push_cmd.is_query = is_query;
    push_cmd.slot     = req.slot[SLOT_W-1:0];
    push_cmd.pos_x    = req.pos_x;
    push_cmd.pos_y    = req.pos_y;
    push_cmd.now_ms   = req.now_ms;
  end

endmodule

/* sv/apst_queue.sv */
// ----------------------------------------------------------------------------
// apst_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module apst_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  apst_pkg::apst_cmd_t push_cmd,
  output logic                full,
  output logic                cmd_valid,
  input  logic                cmd_ready,
  output apst_pkg::apst_cmd_t cmd
);
  import apst_pkg::*;

  apst_cmd_t         entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              pop;

  assign full      = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = entries[rd_ptr];
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* sv/apst_back.sv */
// ----------------------------------------------------------------------------
// apst_back
// Slot table and scan engine: applies updates, scans slots for queries and
// drives the registered response.
// ----------------------------------------------------------------------------
module apst_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  apst_pkg::apst_cmd_t cmd,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output apst_pkg::apst_out_t rsp
);
  import apst_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state;

  logic signed [15:0] tbl_x     [NUM_SLOTS];
  logic signed [15:0] tbl_y     [NUM_SLOTS];
  logic [31:0]        tbl_stamp [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] tbl_valid;

  logic [15:0]        max_age;
  logic [SLOT_W-1:0]  idx;
  logic [31:0]        qnow;
  logic               pend_valid;
  logic [SLOT_W-1:0]  pend_idx;
  logic signed [15:0] pend_x;
  logic signed [15:0] pend_y;

  logic [31:0] age;
  logic        qualify;
  logic        out_free;
  logic        step_ok;
  logic        last_idx;
  logic        do_update;
  logic        rsp_load;

  assign cmd_ready = (state == S_IDLE);
  assign do_update = cmd_valid && cmd_ready && !cmd.is_query;

  // age by wrapping subtraction, a stamp in the future looks very old
  assign age      = qnow - tbl_stamp[idx];
  assign qualify  = tbl_valid[idx] && (age <= {16'b0, max_age});
  assign out_free = !rsp_valid || rsp_ready;
  // a fresh slot pushes the held one out, which needs a free output register
  assign step_ok  = !(qualify && pend_valid) || out_free;
  assign last_idx = (idx == SLOT_W'(NUM_SLOTS - 1));
  assign rsp_load = ((state == S_SCAN) && step_ok && qualify && pend_valid) ||
                    ((state == S_FINISH) && out_free);

  always_ff @(posedge clk) begin
    if (do_update) begin
      tbl_x[cmd.slot]     <= cmd.pos_x;
      tbl_y[cmd.slot]     <= cmd.pos_y;
      tbl_stamp[cmd.slot] <= cmd.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_age <= 16'd1000;
    end else if (cfg_we) begin
      max_age <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      tbl_valid  <= '0;
      idx        <= '0;
      pend_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (do_update) begin
            tbl_valid[cmd.slot] <= 1'b1;
          end else if (cmd_valid) begin
            qnow       <= cmd.now_ms;
            idx        <= '0;
            pend_valid <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (step_ok) begin
            if (qualify) begin
              if (pend_valid) begin
                rsp.found      <= 1'b1;
                rsp.slot_index <= 4'(pend_idx);
                rsp.out_x      <= pend_x;
                rsp.out_y      <= pend_y;
                rsp.last       <= 1'b0;
              end
              pend_valid <= 1'b1;
              pend_idx   <= idx;
              pend_x     <= tbl_x[idx];
              pend_y     <= tbl_y[idx];
            end else begin
              tbl_valid[idx] <= 1'b0;
            end
            if (last_idx) begin
              state <= S_FINISH;
            end else begin
              idx <= idx + SLOT_W'(1);
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            rsp.last  <= 1'b1;
            if (pend_valid) begin
              rsp.found      <= 1'b1;
              rsp.slot_index <= 4'(pend_idx);
              rsp.out_x      <= pend_x;
              rsp.out_y      <= pend_y;
            end else begin
              rsp.found      <= 1'b0;
              rsp.slot_index <= '0;
              rsp.out_x      <= '0;
              rsp.out_y      <= '0;
            end
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* sv/aging_position_slot_table_unit.sv */
// ----------------------------------------------------------------------------
// aging_position_slot_table_unit
// Table of target slots with position, timestamp and aging-based queries.
// ----------------------------------------------------------------------------
// Updates that arrive back to back are applied one per cycle in the table
// engine. A query scans the slots one per cycle through a single age
// comparator, unless the response side stalls, and occupies the engine from
// being taken from the queue until its final result is loaded into the
// output register. Requests are buffered in a four-entry command queue, so
// the request side keeps accepting transactions while a scan is running
// until the queue fills. Updates naming a slot at or above NUM_SLOTS are
// accepted and dropped. Results of a query come out in ascending slot order,
// the final one marked with last; a query with no fresh slot gives one
// result with found low.
module aging_position_slot_table_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data,
  input  logic                req_valid,
  output logic                req_ready,
  input  apst_pkg::apst_in_t  req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output apst_pkg::apst_out_t rsp
);
  import apst_pkg::*;

  logic      push;
  apst_cmd_t push_cmd;
  logic      full;
  logic      cmd_valid;
  logic      cmd_ready;
  apst_cmd_t cmd;

  apst_front u_front (
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .full      (full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  apst_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  apst_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the aging position slot table unit.
// ----------------------------------------------------------------------------
// Updates and queries go in over the request channel. A behavioral copy of the
// slot table works out the results of every accepted query, and the response
// checker compares each returned transaction against them in order. Directed
// tests cover the reset state, the field extremes, the age limit boundary,
// out-of-range slots, stamps in the future, a full table and a zero age limit.
// A forced response stall fills the command queue. Random phases then run
// under three idle patterns and several age limits.
// ----------------------------------------------------------------------------
module testbench;
  import apst_pkg::*;

  localparam int SETTLE_CYCLES  = (QUEUE_DEPTH + 1) * (NUM_SLOTS + 2) + 8;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int STALL_CYCLES   = 300;

  logic      clk;
  logic      rst = 1'b1;
  logic      cfg_we = 1'b0;
  logic [15:0] cfg_data = 16'd0;
  logic      req_valid = 1'b0;
  logic      req_ready;
  apst_in_t  req = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  apst_out_t rsp;

  // behavioral copy of the slot table
  logic signed [15:0] tbl_x     [NUM_SLOTS];
  logic signed [15:0] tbl_y     [NUM_SLOTS];
  logic               tbl_live  [NUM_SLOTS];
  logic [31:0]        tbl_stamp [NUM_SLOTS];
  logic [15:0]        age_limit;

  apst_out_t   pending_reports[$];
  int          errors = 0;
  int          send_idle_pct = 24;
  int          recv_idle_pct = 70;
  int          stall_asked = 0;
  int          stall_granted = 0;
  int          stall_left = 0;
  logic [31:0] clock_ms;

  aging_position_slot_table_unit uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // updates the table copy and queues the reports a query gives
  task automatic table_step(input apst_in_t t);
    apst_out_t r;
    logic      fresh [NUM_SLOTS];
    int        hits;
    int        final_hit;
    logic [31:0] age;
    if (t.opcode == OP_UPDATE) begin
      if (t.slot < NUM_SLOTS) begin
        tbl_x[t.slot]     = t.pos_x;
        tbl_y[t.slot]     = t.pos_y;
        tbl_live[t.slot]  = 1'b1;
        tbl_stamp[t.slot] = t.now_ms;
      end
    end else begin
      hits = 0;
      final_hit = 0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        age = t.now_ms - tbl_stamp[i];
        fresh[i] = tbl_live[i] && (age <= {16'd0, age_limit});
        if (fresh[i]) begin
          hits++;
          final_hit = i;
        end else begin
          tbl_live[i] = 1'b0;
        end
      end
      if (hits == 0) begin
        r = '0;
        r.last = 1'b1;
        pending_reports.push_back(r);
      end else begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (fresh[i]) begin
            r.found      = 1'b1;
            r.slot_index = 4'(i);
            r.out_x      = tbl_x[i];
            r.out_y      = tbl_y[i];
            r.last       = (i == final_hit);
            pending_reports.push_back(r);
          end
        end
      end
    end
  endtask

  task automatic check_report(input apst_out_t got);
    apst_out_t want;
    if (pending_reports.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
      errors++;
    end else begin
      want = pending_reports.pop_front();
      if (got.found !== want.found) begin
        $display("%0t: found mismatch, expected %0b, actual %0b", $time, want.found, got.found);
        errors++;
      end
      if (got.slot_index !== want.slot_index) begin
        $display("%0t: slot_index mismatch, expected %0d, actual %0d", $time,
                 want.slot_index, got.slot_index);
        errors++;
      end
      if (got.out_x !== want.out_x) begin
        $display("%0t: out_x mismatch, expected %0d, actual %0d", $time, want.out_x, got.out_x);
        errors++;
      end
      if (got.out_y !== want.out_y) begin
        $display("%0t: out_y mismatch, expected %0d, actual %0d", $time, want.out_y, got.out_y);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last mismatch, expected %0b, actual %0b", $time, want.last, got.last);
        errors++;
      end
    end
  endtask

  // response side: check each transaction, then pick the next ready value
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      check_report(rsp);
    end
    if (stall_granted != stall_asked) begin
      stall_granted = stall_asked;
      stall_left = STALL_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("aging_position_slot_table_unit verification failed");
    $finish;
  end

  task automatic send_txn(input apst_in_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= t;
    do begin
      @(posedge clk);
    end while (!req_ready);
    table_step(t);
  endtask

  task automatic send_update(input logic [3:0] slot, input logic [15:0] x,
                             input logic [15:0] y, input logic [31:0] now);
    apst_in_t t;
    t.opcode = OP_UPDATE;
    t.slot   = slot;
    t.pos_x  = x;
    t.pos_y  = y;
    t.now_ms = now;
    send_txn(t);
  endtask

  task automatic send_query(input logic [31:0] now);
    apst_in_t t;
    t.opcode = OP_QUERY;
    t.slot   = 4'($urandom);
    t.pos_x  = 16'($urandom);
    t.pos_y  = 16'($urandom);
    t.now_ms = now;
    send_txn(t);
  endtask

  // updates leave no result behind, so give the command queue time to empty
  task automatic wait_quiet;
    req_valid <= 1'b0;
    while (pending_reports.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_age_limit(input logic [15:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    age_limit = value;
  endtask

  task automatic test_reset_state;
    send_query(32'd0);
  endtask

  task automatic test_field_extremes;
    send_update(4'd0, 16'h8000, 16'h7FFF, 32'hFFFF_FFF0);
    send_update(4'(NUM_SLOTS - 1), 16'h7FFF, 16'h8000, 32'h0000_0100);
    send_update(4'(NUM_SLOTS), 16'h1234, 16'h5678, 32'd0);
    send_update(4'd15, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    // slot 0 ages exactly to the limit across the counter wrap, then one past
    send_query(32'h0000_03D8);
    send_query(32'h0000_03D9);
  endtask

  task automatic test_future_stamp;
    send_update(4'd5, 16'h0010, 16'hFFF0, 32'h0000_07D0);
    send_query(32'h0000_03D9);
  endtask

  task automatic test_full_table;
    wait_quiet;
    write_age_limit(16'hFFFF);
    for (int i = 0; i < NUM_SLOTS; i++) begin
      send_update(4'(i), 16'($urandom), 16'($urandom), clock_ms + 32'(i));
    end
    send_query(clock_ms + 32'd20);
  endtask

  task automatic test_zero_age;
    wait_quiet;
    write_age_limit(16'd0);
    clock_ms = clock_ms + 32'd70000;
    send_update(4'd3, 16'($urandom), 16'($urandom), clock_ms);
    send_query(clock_ms);
    send_query(clock_ms + 32'd1);
  endtask

  task automatic test_backpressure;
    wait_quiet;
    write_age_limit(16'hFFFF);
    stall_asked++;
    for (int k = 0; k < 8; k++) begin
      send_update(4'(k), 16'($urandom), 16'($urandom), clock_ms);
      send_query(clock_ms);
    end
  endtask

  task automatic run_random_phase(input int n_items, input int snd_pct, input int rcv_pct,
                                  input logic [15:0] limit);
    apst_in_t t;
    int       done;
    int       roll;
    wait_quiet;
    write_age_limit(limit);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    done = 0;
    while (done < n_items) begin
      roll = $urandom_range(99);
      if (roll < 3) begin
        clock_ms = $urandom;
      end else if (roll < 7) begin
        // stepping back leaves stamps in the future
        clock_ms = clock_ms - $urandom_range(1, age_limit / 2 + 1);
      end else begin
        clock_ms = clock_ms + $urandom_range(0, age_limit / 4 + 1);
      end
      roll = $urandom_range(99);
      t.slot  = 4'($urandom_range(0, NUM_SLOTS - 1));
      t.pos_x = 16'($urandom);
      t.pos_y = 16'($urandom);
      if (roll < 28) begin
        t.opcode = OP_QUERY;
        t.slot   = 4'($urandom);
        t.now_ms = clock_ms;
      end else begin
        t.opcode = OP_UPDATE;
        if (roll < 35) begin
          t.slot = 4'($urandom_range(NUM_SLOTS, 15));
        end
        t.now_ms = clock_ms - $urandom_range(0, age_limit + 2);
      end
      send_txn(t);
      if (t.opcode == OP_QUERY || t.slot < NUM_SLOTS) begin
        done++;
      end
    end
  endtask

  initial begin
    age_limit = 16'd1000;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      tbl_x[i]     = '0;
      tbl_y[i]     = '0;
      tbl_live[i]  = 1'b0;
      tbl_stamp[i] = '0;
    end
    clock_ms = $urandom;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_reset_state;
    test_field_extremes;
    test_future_stamp;
    test_full_table;
    test_zero_age;
    test_backpressure;
    run_random_phase(50, 24, 70, 16'($urandom_range(200, 5000)));
    run_random_phase(50, 70, 24, 16'hFFFF);
    run_random_phase(50, 0, 0, 16'($urandom_range(0, 50)));

    wait_quiet;
    if (errors == 0) begin
      $display("aging_position_slot_table_unit verification clean");
    end else begin
      $display("aging_position_slot_table_unit verification failed");
    end
    $finish;
  end

endmodule
